// ===== src/assert_macros.svh =====
// Shared assertion macros for the line encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/alie_pkg.sv =====
package alie_pkg;

   localparam int TOKEN_CHARS = 8;
   localparam int LEN_W = $clog2(TOKEN_CHARS + 1);

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic [15:0] LIT_MAX = 16'd32767;
   localparam logic [15:0] LIT_SAT = 16'd32768;

   localparam logic [1:0] KIND_SKIP = 2'd0;
   localparam logic [1:0] KIND_ADDR = 2'd1;
   localparam logic [1:0] KIND_COMP = 2'd2;

   // Lookup results carry the miss flag in the top bit and a zero code on a miss.
   localparam logic [7:0] COMP_MISS = 8'h80;
   localparam logic [3:0] FIELD_MISS = 4'h8;

   typedef enum logic [7:0] {
      PH_START = 8'b0000_0001,
      PH_ADDR  = 8'b0000_0010,
      PH_SKIP  = 8'b0000_0100,
      PH_FIRST = 8'b0000_1000,
      PH_COMP  = 8'b0001_0000,
      PH_JUMP  = 8'b0010_0000,
      PH_CDONE = 8'b0100_0000,
      PH_ADONE = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [TOKEN_CHARS-1:0][7:0] chars;
      logic [LEN_W-1:0]            len;
      logic                        broken;
   } tok_type;

   typedef struct packed {
      phase_type   phase;
      tok_type     tok;
      logic        space;
      logic        slash;
      logic [3:0]  held_dest;
      logic [7:0]  held_comp;
      logic [15:0] lit;
   } line_state_type;

   typedef struct packed {
      logic [7:0] comp;
      logic [3:0] dest;
      logic [3:0] jump;
   } lookup_type;

   typedef struct packed {
      logic [1:0]  line_kind;
      logic [14:0] literal_value;
      logic        literal_bad;
      logic [6:0]  comp_code;
      logic [2:0]  dest_code;
      logic [2:0]  jump_code;
      logic        comp_bad;
      logic        dest_bad;
      logic        jump_bad;
   } rsp_data_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Keys hold up to four characters, first character in the top byte, zero padded.
   function automatic logic [7:0] comp_find(logic [31:0] key);
      case (key)
         {"0", 24'h0}:   return {1'b0, 7'd42};
         {"1", 24'h0}:   return {1'b0, 7'd63};
         {"-1", 16'h0}:  return {1'b0, 7'd58};
         {"D", 24'h0}:   return {1'b0, 7'd12};
         {"A", 24'h0}:   return {1'b0, 7'd48};
         {"!D", 16'h0}:  return {1'b0, 7'd13};
         {"!A", 16'h0}:  return {1'b0, 7'd49};
         {"-D", 16'h0}:  return {1'b0, 7'd15};
         {"-A", 16'h0}:  return {1'b0, 7'd51};
         {"D+1", 8'h0}:  return {1'b0, 7'd31};
         {"A+1", 8'h0}:  return {1'b0, 7'd55};
         {"D-1", 8'h0}:  return {1'b0, 7'd14};
         {"A-1", 8'h0}:  return {1'b0, 7'd50};
         {"D+A", 8'h0}:  return {1'b0, 7'd2};
         {"D-A", 8'h0}:  return {1'b0, 7'd19};
         {"A-D", 8'h0}:  return {1'b0, 7'd7};
         {"D&A", 8'h0}:  return {1'b0, 7'd0};
         {"D|A", 8'h0}:  return {1'b0, 7'd21};
         {"M", 24'h0}:   return {1'b0, 7'd112};
         {"!M", 16'h0}:  return {1'b0, 7'd113};
         {"-M", 16'h0}:  return {1'b0, 7'd115};
         {"M+1", 8'h0}:  return {1'b0, 7'd119};
         {"M-1", 8'h0}:  return {1'b0, 7'd114};
         {"D+M", 8'h0}:  return {1'b0, 7'd66};
         {"D-M", 8'h0}:  return {1'b0, 7'd83};
         {"M-D", 8'h0}:  return {1'b0, 7'd71};
         {"D&M", 8'h0}:  return {1'b0, 7'd64};
         {"D|M", 8'h0}:  return {1'b0, 7'd85};
         default:        return COMP_MISS;
      endcase
   endfunction

   function automatic logic [3:0] dest_find(logic [31:0] key);
      case (key)
         "null":         return 4'd0;
         {"M", 24'h0}:   return 4'd1;
         {"D", 24'h0}:   return 4'd2;
         {"MD", 16'h0}:  return 4'd3;
         {"A", 24'h0}:   return 4'd4;
         {"AM", 16'h0}:  return 4'd5;
         {"AD", 16'h0}:  return 4'd6;
         {"AMD", 8'h0}:  return 4'd7;
         default:        return FIELD_MISS;
      endcase
   endfunction

   function automatic logic [3:0] jump_find(logic [31:0] key);
      case (key)
         "null":         return 4'd0;
         {"JGT", 8'h0}:  return 4'd1;
         {"JEQ", 8'h0}:  return 4'd2;
         {"JGE", 8'h0}:  return 4'd3;
         {"JLT", 8'h0}:  return 4'd4;
         {"JNE", 8'h0}:  return 4'd5;
         {"JLE", 8'h0}:  return 4'd6;
         {"JMP", 8'h0}:  return 4'd7;
         default:        return FIELD_MISS;
      endcase
   endfunction

endpackage

// ===== src/alie_req_if.sv =====
interface alie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink (input valid, input char_code, input line_end, output ready);
endinterface

// ===== src/alie_rsp_if.sv =====
interface alie_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  line_kind;
   logic [14:0] literal_value;
   logic        literal_bad;
   logic [6:0]  comp_code;
   logic [2:0]  dest_code;
   logic [2:0]  jump_code;
   logic        comp_bad;
   logic        dest_bad;
   logic        jump_bad;

   modport source (output valid, output line_kind, output literal_value,
                   output literal_bad, output comp_code, output dest_code,
                   output jump_code, output comp_bad, output dest_bad,
                   output jump_bad, input ready);
   modport sink (input valid, input line_kind, input literal_value,
                 input literal_bad, input comp_code, input dest_code,
                 input jump_code, input comp_bad, input dest_bad,
                 input jump_bad, output ready);
endinterface

// ===== src/alie_match.sv =====
module alie_match (
   input  alie_pkg::tok_type    tok,
   output alie_pkg::lookup_type lookup
);

   logic [31:0] key;
   logic        miss;

   // Characters past the token length are never compared.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         key[31 - 8*k -: 8] = (tok.len > alie_pkg::LEN_W'(k)) ? tok.chars[k] : alie_pkg::CH_NUL;
      end
   end

   assign miss = tok.broken || (tok.len > alie_pkg::LEN_W'(4));

   always_comb begin
      if (miss) begin
         lookup.comp = alie_pkg::COMP_MISS;
         lookup.dest = alie_pkg::FIELD_MISS;
         lookup.jump = alie_pkg::FIELD_MISS;
      end else begin
         lookup.comp = alie_pkg::comp_find(key);
         lookup.dest = alie_pkg::dest_find(key);
         lookup.jump = alie_pkg::jump_find(key);
      end
   end

endmodule

// ===== src/assembly_line_instruction_encoder_core.sv =====
// Channel   Direction  Payload
// req_chan  in         char_code, line_end
// rsp_chan  out        line_kind, literal_value, literal_bad, comp/dest/jump codes and flags
//
// Each side takes one transaction per cycle unless stalled; the character stage computes the
// next line state from the token compare and the multiply-by-ten accumulate.
// A line end passes the input, snapshot and result registers before its result is offered.
// Reset is synchronous and clears all control state; the token characters are not cleared.
// While the result stage stalls, ordinary characters keep flowing; a line end waits only when
// both the snapshot and the result register hold a line.
`include "assert_macros.svh"

module assembly_line_instruction_encoder_core (
   input logic        clock,
   input logic        reset,
   alie_req_if.sink   req_chan,
   alie_rsp_if.source rsp_chan
);

   function automatic logic is_done(alie_pkg::phase_type ph);
      return ph inside {alie_pkg::PH_SKIP, alie_pkg::PH_CDONE, alie_pkg::PH_ADONE};
   endfunction

   function automatic alie_pkg::line_state_type clear_token(alie_pkg::line_state_type s);
      alie_pkg::line_state_type r;
      r = s;
      r.tok.len = '0;
      r.tok.broken = 1'b0;
      r.space = 1'b0;
      return r;
   endfunction

   function automatic alie_pkg::line_state_type line_clear(alie_pkg::line_state_type s);
      alie_pkg::line_state_type r;
      r = clear_token(s);
      r.phase = alie_pkg::PH_START;
      r.slash = 1'b0;
      r.held_dest = '0;
      r.held_comp = '0;
      r.lit = '0;
      return r;
   endfunction

   function automatic alie_pkg::line_state_type load_null(alie_pkg::line_state_type s);
      alie_pkg::line_state_type r;
      r = clear_token(s);
      r.tok.chars[0] = "n";
      r.tok.chars[1] = "u";
      r.tok.chars[2] = "l";
      r.tok.chars[3] = "l";
      r.tok.len = alie_pkg::LEN_W'(4);
      return r;
   endfunction

   function automatic alie_pkg::line_state_type token_add(alie_pkg::line_state_type s,
                                                         logic [7:0] c);
      alie_pkg::line_state_type r;
      r = s;
      if (alie_pkg::is_blank(c)) begin
         if (s.tok.len != '0 || s.tok.broken) r.space = 1'b1;
      end else begin
         if (s.space) r.tok.broken = 1'b1;
         r.space = 1'b0;
         if (s.tok.len < alie_pkg::LEN_W'(alie_pkg::TOKEN_CHARS)) begin
            for (int i = 0; i < alie_pkg::TOKEN_CHARS; i++) begin
               if (s.tok.len == alie_pkg::LEN_W'(i)) r.tok.chars[i] = c;
            end
            r.tok.len = s.tok.len + alie_pkg::LEN_W'(1);
         end else begin
            r.tok.broken = 1'b1;
         end
      end
      return r;
   endfunction

   // Address constant: optional sign, then digits; the sum saturates just above the range.
   function automatic alie_pkg::line_state_type addr_take(alie_pkg::line_state_type s,
                                                         logic [7:0] c);
      alie_pkg::line_state_type r;
      logic [19:0] acc;
      logic        lead;
      r = s;
      acc = ({4'd0, s.lit} << 3) + ({4'd0, s.lit} << 1) + {12'd0, c - alie_pkg::CH_ZERO};
      lead = (s.tok.len == '0) && !s.held_dest[0];
      if (!s.tok.broken) begin
         if (c >= alie_pkg::CH_ZERO && c <= alie_pkg::CH_NINE) begin
            r.lit = (acc > {4'd0, alie_pkg::LIT_SAT}) ? alie_pkg::LIT_SAT : acc[15:0];
            r.tok.len = alie_pkg::LEN_W'(1);
         end else if (lead && (c == alie_pkg::CH_PLUS || c == alie_pkg::CH_MINUS)) begin
            r.held_dest = (c == alie_pkg::CH_MINUS) ? 4'd3 : 4'd1;
         end else if (!(lead && alie_pkg::is_blank(c))) begin
            r.tok.broken = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic alie_pkg::line_state_type take(alie_pkg::line_state_type s,
                                                    logic [7:0] c,
                                                    alie_pkg::lookup_type lk);
      alie_pkg::line_state_type r;
      r = s;
      case (s.phase)
         alie_pkg::PH_START: begin
            if (!alie_pkg::is_blank(c)) begin
               if (c == alie_pkg::CH_AT) begin
                  r = clear_token(s);
                  r.phase = alie_pkg::PH_ADDR;
                  r.held_dest = '0;
                  r.lit = '0;
               end else if (c == alie_pkg::CH_LPAREN) begin
                  r.phase = alie_pkg::PH_SKIP;
               end else begin
                  r = token_add(s, c);
                  r.phase = alie_pkg::PH_FIRST;
               end
            end
         end
         alie_pkg::PH_ADDR: begin
            r = addr_take(s, c);
         end
         alie_pkg::PH_FIRST: begin
            if (c == alie_pkg::CH_EQ) begin
               r = clear_token(s);
               r.held_dest = lk.dest;
               r.phase = alie_pkg::PH_COMP;
            end else if (c == alie_pkg::CH_SEMI) begin
               r = clear_token(s);
               r.held_dest = '0;
               r.held_comp = lk.comp;
               r.phase = alie_pkg::PH_JUMP;
            end else begin
               r = token_add(s, c);
            end
         end
         alie_pkg::PH_COMP: begin
            if (c == alie_pkg::CH_SEMI) begin
               r = clear_token(s);
               r.held_comp = lk.comp;
               r.phase = alie_pkg::PH_JUMP;
            end else begin
               r = token_add(s, c);
            end
         end
         alie_pkg::PH_JUMP: begin
            r = token_add(s, c);
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   function automatic alie_pkg::line_state_type enter_comment(alie_pkg::line_state_type s,
                                                             alie_pkg::lookup_type lk);
      alie_pkg::line_state_type r;
      r = s;
      case (s.phase)
         alie_pkg::PH_START, alie_pkg::PH_SKIP: begin
            r.phase = alie_pkg::PH_SKIP;
         end
         alie_pkg::PH_ADDR: begin
            r.phase = alie_pkg::PH_ADONE;
         end
         alie_pkg::PH_FIRST, alie_pkg::PH_COMP: begin
            if (s.phase == alie_pkg::PH_FIRST) r.held_dest = '0;
            r.held_comp = lk.comp;
            r = load_null(r);
            r.phase = alie_pkg::PH_CDONE;
         end
         alie_pkg::PH_JUMP: begin
            r.phase = alie_pkg::PH_CDONE;
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   logic                     in_valid_ff;
   logic [7:0]               in_char_ff;
   logic                     in_end_ff;
   alie_pkg::line_state_type state_ff;
   alie_pkg::line_state_type state_in;
   logic                     snap_valid_ff;
   logic                     snap_valid_in;
   alie_pkg::line_state_type snap_ff;
   alie_pkg::line_state_type snap_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   alie_pkg::rsp_data_type   rsp_data_ff;
   alie_pkg::rsp_data_type   rsp_data_in;

   logic                     req_ready;
   logic                     a_fire;
   logic                     b_free;
   logic                     c_load;
   logic                     active;
   alie_pkg::line_state_type s1;
   alie_pkg::line_state_type s2;
   alie_pkg::line_state_type s3;
   alie_pkg::lookup_type     lk1;
   alie_pkg::lookup_type     lk2;
   logic [7:0]               comp_sel;
   logic [3:0]               dest_sel;
   logic [3:0]               jump_sel;
   logic                     lit_bad;

   assign c_load = snap_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign b_free = !snap_valid_ff || c_load;
   assign a_fire = in_valid_ff && (!in_end_ff || b_free);
   assign req_ready = !in_valid_ff || a_fire;
   assign req_chan.ready = req_ready;

   // A held slash followed by another character is an ordinary character.
   always_comb begin
      active = (in_char_ff != alie_pkg::CH_NUL) && !is_done(state_ff.phase);
      s1 = state_ff;
      if (active && in_char_ff != alie_pkg::CH_SLASH && state_ff.slash) begin
         s1.slash = 1'b0;
         s1 = take(s1, alie_pkg::CH_SLASH, '0);
      end
   end

   alie_match u_match_char (
      .tok    (s1.tok),
      .lookup (lk1)
   );

   always_comb begin
      s2 = s1;
      if (active) begin
         if (in_char_ff == alie_pkg::CH_SLASH) begin
            if (state_ff.slash) begin
               s2.slash = 1'b0;
               s2 = enter_comment(s2, lk1);
            end else begin
               s2.slash = 1'b1;
            end
         end else begin
            s2 = take(s1, in_char_ff, lk1);
         end
      end
      s3 = s2;
      if (s2.slash && !is_done(s2.phase)) begin
         s3.slash = 1'b0;
         s3 = take(s3, alie_pkg::CH_SLASH, '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      snap_in = snap_ff;
      if (a_fire) begin
         if (in_end_ff) begin
            state_in = line_clear(s2);
            snap_in = s3;
         end else begin
            state_in = s2;
         end
      end
      snap_valid_in = (snap_valid_ff && !c_load) || (a_fire && in_end_ff);
      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || c_load;
   end

   alie_match u_match_line (
      .tok    (snap_ff.tok),
      .lookup (lk2)
   );

   // An unfinished dest/comp part closes with an implied null jump.
   always_comb begin
      rsp_data_in = '0;
      comp_sel = '0;
      dest_sel = '0;
      jump_sel = '0;
      lit_bad = (snap_ff.tok.len == '0) || (snap_ff.held_dest[1] && snap_ff.lit != '0) ||
                (snap_ff.lit > alie_pkg::LIT_MAX);
      if (snap_ff.phase inside {alie_pkg::PH_ADDR, alie_pkg::PH_ADONE}) begin
         rsp_data_in.line_kind = alie_pkg::KIND_ADDR;
         rsp_data_in.literal_bad = lit_bad;
         rsp_data_in.literal_value = lit_bad ? '0 : snap_ff.lit[14:0];
      end else if (snap_ff.phase inside {alie_pkg::PH_FIRST, alie_pkg::PH_COMP}) begin
         rsp_data_in.line_kind = alie_pkg::KIND_COMP;
         comp_sel = lk2.comp;
         dest_sel = (snap_ff.phase == alie_pkg::PH_FIRST) ? '0 : snap_ff.held_dest;
      end else if (snap_ff.phase inside {alie_pkg::PH_JUMP, alie_pkg::PH_CDONE}) begin
         rsp_data_in.line_kind = alie_pkg::KIND_COMP;
         comp_sel = snap_ff.held_comp;
         dest_sel = snap_ff.held_dest;
         jump_sel = lk2.jump;
      end
      rsp_data_in.comp_code = comp_sel[6:0];
      rsp_data_in.comp_bad = comp_sel[7];
      rsp_data_in.dest_code = dest_sel[2:0];
      rsp_data_in.dest_bad = dest_sel[3];
      rsp_data_in.jump_code = jump_sel[2:0];
      rsp_data_in.jump_bad = jump_sel[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= line_clear(state_ff);
         snap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_chan.valid;
         state_ff <= state_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_char_ff <= req_chan.char_code;
         in_end_ff <= req_chan.line_end;
      end
      snap_ff <= snap_in;
      if (c_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.line_kind = rsp_data_ff.line_kind;
   assign rsp_chan.literal_value = rsp_data_ff.literal_value;
   assign rsp_chan.literal_bad = rsp_data_ff.literal_bad;
   assign rsp_chan.comp_code = rsp_data_ff.comp_code;
   assign rsp_chan.dest_code = rsp_data_ff.dest_code;
   assign rsp_chan.jump_code = rsp_data_ff.jump_code;
   assign rsp_chan.comp_bad = rsp_data_ff.comp_bad;
   assign rsp_chan.dest_bad = rsp_data_ff.dest_bad;
   assign rsp_chan.jump_bad = rsp_data_ff.jump_bad;

   `ASSERT_NEXT(a_line_end_restarts, clock, reset, a_fire && in_end_ff, state_ff.phase == alie_pkg::PH_START && !state_ff.slash && state_ff.tok.len == '0 && state_ff.lit == '0, "Line state not cleared after a line-end transaction.")

   `ASSERT_SAME(a_kind_known, clock, reset, rsp_valid_ff, rsp_chan.line_kind == alie_pkg::KIND_SKIP || rsp_chan.line_kind == alie_pkg::KIND_ADDR || rsp_chan.line_kind == alie_pkg::KIND_COMP, "Result carries an unknown line kind.")

   `ASSERT_SAME(a_non_compute_clean, clock, reset, rsp_valid_ff && rsp_chan.line_kind != alie_pkg::KIND_COMP, rsp_chan.comp_code == '0 && rsp_chan.dest_code == '0 && rsp_chan.jump_code == '0 && !rsp_chan.comp_bad && !rsp_chan.dest_bad && !rsp_chan.jump_bad, "Compute fields set on a non-compute result.")

   `ASSERT_SAME(a_bad_means_zero, clock, reset, rsp_valid_ff, (!rsp_chan.literal_bad || rsp_chan.literal_value == '0) && (!rsp_chan.comp_bad || rsp_chan.comp_code == '0) && (!rsp_chan.dest_bad || rsp_chan.dest_code == '0) && (!rsp_chan.jump_bad || rsp_chan.jump_code == '0), "A flagged field carries a non-zero code.")

endmodule

// ===== verif/assembly_line_instruction_encoder_core_test.sv =====
`timescale 1ns / 100ps

module assembly_line_instruction_encoder_core_test;

   localparam int QUIET_LIMIT = 5000;

   typedef enum {GROUP_COMP, GROUP_DEST, GROUP_JUMP} mnemonic_group_type;

   string comp_names [28] = '{"0", "1", "-1", "D", "A", "!D", "!A", "-D", "-A", "D+1", "A+1",
                              "D-1", "A-1", "D+A", "D-A", "A-D", "D&A", "D|A", "M", "!M", "-M",
                              "M+1", "M-1", "D+M", "D-M", "M-D", "D&M", "D|M"};
   int    comp_values [28] = '{42, 63, 58, 12, 48, 13, 49, 15, 51, 31, 55, 14, 50, 2, 19, 7, 0,
                               21, 112, 113, 115, 119, 114, 66, 83, 71, 64, 85};
   string dest_names [8] = '{"null", "M", "D", "MD", "A", "AM", "AD", "AMD"};
   string jump_names [8] = '{"null", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

   logic clock;
   logic reset;

   alie_req_if req_chan ();
   alie_rsp_if rsp_chan ();

   assembly_line_instruction_encoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Line state of the encoder as the checker sees it.
   alie_pkg::phase_type ph;
   logic [7:0] tok_chars [alie_pkg::TOKEN_CHARS];
   int         tok_len;
   bit         tok_broken;
   bit         space_pend;
   bit         slash_pend;
   logic [7:0] held_dest;
   logic [7:0] held_comp;
   int         lit_sum;

   alie_pkg::rsp_data_type encodings_due [$];
   alie_pkg::rsp_data_type line_want;
   logic [7:0]   line_buf [$];
   int           mismatch_count;
   int           chars_sent;
   int           quiet_cycles;
   int           src_gap_odds;
   int           snk_gap_odds;
   int           hold_off_request;
   int           stall_left;

   function automatic bit blank_char(logic [7:0] c);
      return c == alie_pkg::CH_SPACE || (c >= alie_pkg::CH_TAB && c <= alie_pkg::CH_CR);
   endfunction

   function automatic void clear_token();
      tok_len    = 0;
      tok_broken = 1'b0;
      space_pend = 1'b0;
   endfunction

   function automatic void reset_line();
      ph = alie_pkg::PH_START;
      clear_token();
      slash_pend = 1'b0;
      held_dest  = '0;
      held_comp  = '0;
      lit_sum    = 0;
   endfunction

   function automatic logic [7:0] token_code(mnemonic_group_type grp);
      string key;
      key = "";
      if (tok_broken) return alie_pkg::COMP_MISS;
      for (int k = 0; k < tok_len; k++) key = $sformatf("%s%c", key, tok_chars[k]);
      case (grp)
         GROUP_COMP: foreach (comp_names[i]) if (comp_names[i] == key) return 8'(comp_values[i]);
         GROUP_DEST: foreach (dest_names[i]) if (dest_names[i] == key) return 8'(i);
         default:    foreach (jump_names[i]) if (jump_names[i] == key) return 8'(i);
      endcase
      return alie_pkg::COMP_MISS;
   endfunction

   function automatic void token_add(logic [7:0] c);
      if (blank_char(c)) begin
         if (tok_len > 0 || tok_broken) space_pend = 1'b1;
         return;
      end
      if (space_pend) tok_broken = 1'b1;
      space_pend = 1'b0;
      if (tok_len < alie_pkg::TOKEN_CHARS) begin
         tok_chars[tok_len] = c;
         tok_len++;
      end else begin
         tok_broken = 1'b1;
      end
   endfunction

   // With no jump field the jump part reads as null.
   function automatic void close_comp();
      if (ph == alie_pkg::PH_FIRST) held_dest = '0;
      held_comp = token_code(GROUP_COMP);
      clear_token();
      tok_chars[0] = "n";
      tok_chars[1] = "u";
      tok_chars[2] = "l";
      tok_chars[3] = "l";
      tok_len = 4;
      ph = alie_pkg::PH_CDONE;
   endfunction

   function automatic void address_char(logic [7:0] c);
      bit sign_seen;
      sign_seen = held_dest[0];
      if (tok_broken) return;
      if (c >= alie_pkg::CH_ZERO && c <= alie_pkg::CH_NINE) begin
         lit_sum = lit_sum * 10 + (int'(c) - int'(alie_pkg::CH_ZERO));
         if (lit_sum > int'(alie_pkg::LIT_SAT)) lit_sum = int'(alie_pkg::LIT_SAT);
         if (tok_len < 15) tok_len++;
      end else if (tok_len == 0 && !sign_seen && blank_char(c)) begin
      end else if (tok_len == 0 && !sign_seen &&
                   (c == alie_pkg::CH_PLUS || c == alie_pkg::CH_MINUS)) begin
         held_dest = (c == alie_pkg::CH_MINUS) ? 8'd3 : 8'd1;
      end else begin
         tok_broken = 1'b1;
      end
   endfunction

   function automatic void parse_char(logic [7:0] c);
      case (ph)
         alie_pkg::PH_START: begin
            if (blank_char(c)) return;
            if (c == alie_pkg::CH_AT) begin
               ph = alie_pkg::PH_ADDR;
               clear_token();
               held_dest = '0;
               lit_sum   = 0;
            end else if (c == alie_pkg::CH_LPAREN) begin
               ph = alie_pkg::PH_SKIP;
            end else begin
               ph = alie_pkg::PH_FIRST;
               token_add(c);
            end
         end
         alie_pkg::PH_ADDR: address_char(c);
         alie_pkg::PH_FIRST: begin
            if (c == alie_pkg::CH_EQ) begin
               held_dest = token_code(GROUP_DEST) & 8'h87;
               if (held_dest[7]) held_dest = 8'(alie_pkg::FIELD_MISS);
               clear_token();
               ph = alie_pkg::PH_COMP;
            end else if (c == alie_pkg::CH_SEMI) begin
               held_dest = '0;
               held_comp = token_code(GROUP_COMP);
               clear_token();
               ph = alie_pkg::PH_JUMP;
            end else begin
               token_add(c);
            end
         end
         alie_pkg::PH_COMP: begin
            if (c == alie_pkg::CH_SEMI) begin
               held_comp = token_code(GROUP_COMP);
               clear_token();
               ph = alie_pkg::PH_JUMP;
            end else begin
               token_add(c);
            end
         end
         alie_pkg::PH_JUMP: token_add(c);
         default: ;
      endcase
   endfunction

   function automatic void enter_comment();
      if (ph == alie_pkg::PH_START || ph == alie_pkg::PH_SKIP) ph = alie_pkg::PH_SKIP;
      else if (ph == alie_pkg::PH_ADDR) ph = alie_pkg::PH_ADONE;
      else if (ph == alie_pkg::PH_FIRST || ph == alie_pkg::PH_COMP) close_comp();
      else if (ph == alie_pkg::PH_JUMP) ph = alie_pkg::PH_CDONE;
   endfunction

   function automatic void scan_char(logic [7:0] c);
      if (c == alie_pkg::CH_NUL || ph == alie_pkg::PH_SKIP || ph == alie_pkg::PH_CDONE ||
          ph == alie_pkg::PH_ADONE) return;
      if (c == alie_pkg::CH_SLASH) begin
         if (slash_pend) begin
            slash_pend = 1'b0;
            enter_comment();
         end else begin
            slash_pend = 1'b1;
         end
         return;
      end
      if (slash_pend) begin
         slash_pend = 1'b0;
         parse_char(alie_pkg::CH_SLASH);
      end
      parse_char(c);
   endfunction

   function automatic bit encode_char(logic [7:0] c, logic last,
                                      output alie_pkg::rsp_data_type enc);
      logic [7:0] jc;
      bit         bad;
      enc = '0;
      scan_char(c);
      if (!last) return 1'b0;
      if (slash_pend && ph != alie_pkg::PH_SKIP && ph != alie_pkg::PH_CDONE &&
          ph != alie_pkg::PH_ADONE) begin
         slash_pend = 1'b0;
         parse_char(alie_pkg::CH_SLASH);
      end
      if (ph == alie_pkg::PH_ADDR || ph == alie_pkg::PH_ADONE) begin
         bad = tok_len == 0 || (held_dest[1] && lit_sum != 0) ||
               lit_sum > int'(alie_pkg::LIT_MAX);
         enc.line_kind     = alie_pkg::KIND_ADDR;
         enc.literal_value = bad ? 15'd0 : 15'(lit_sum);
         enc.literal_bad   = bad;
      end else if (ph == alie_pkg::PH_FIRST || ph == alie_pkg::PH_COMP ||
                   ph == alie_pkg::PH_JUMP || ph == alie_pkg::PH_CDONE) begin
         if (ph == alie_pkg::PH_FIRST || ph == alie_pkg::PH_COMP) close_comp();
         jc = token_code(GROUP_JUMP);
         enc.line_kind = alie_pkg::KIND_COMP;
         enc.comp_code = held_comp[7] ? 7'd0 : held_comp[6:0];
         enc.dest_code = held_dest[3] ? 3'd0 : held_dest[2:0];
         enc.jump_code = jc[7] ? 3'd0 : jc[2:0];
         enc.comp_bad  = held_comp[7];
         enc.dest_bad  = held_dest[3];
         enc.jump_bad  = jc[7];
      end
      reset_line();
      return 1'b1;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (encodings_due.size() == 0) begin
            $error("line result with no line pending: line_kind %0d", rsp_chan.line_kind);
            mismatch_count++;
         end else begin
            line_want = encodings_due.pop_front();
            check_field("line_kind", line_want.line_kind, rsp_chan.line_kind);
            check_field("literal_value", line_want.literal_value, rsp_chan.literal_value);
            check_field("literal_bad", line_want.literal_bad, rsp_chan.literal_bad);
            check_field("comp_code", line_want.comp_code, rsp_chan.comp_code);
            check_field("dest_code", line_want.dest_code, rsp_chan.dest_code);
            check_field("jump_code", line_want.jump_code, rsp_chan.jump_code);
            check_field("comp_bad", line_want.comp_bad, rsp_chan.comp_bad);
            check_field("dest_bad", line_want.dest_bad, rsp_chan.dest_bad);
            check_field("jump_bad", line_want.jump_bad, rsp_chan.jump_bad);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The result side: random stall bursts, plus a long hold-off when one is requested.
   initial begin
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_request > 0) begin
            stall_left = hold_off_request - 1;
            hold_off_request = 0;
            rsp_chan.ready <= 1'b0;
         end else if (snk_gap_odds != 0 && $urandom_range(1, snk_gap_odds) == 1) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      alie_pkg::rsp_data_type enc;
      bit           closes;
      if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      req_chan.line_end  <= last;
      do @(posedge clock); while (!req_chan.ready);
      chars_sent++;
      closes = encode_char(c, last, enc);
      if (closes) encodings_due.push_back(enc);
   endtask

   // Sends the buffered line; an empty line always ends on a transaction with no character.
   task automatic send_line(input bit nul_end);
      bit nul_last;
      nul_last = nul_end || line_buf.size() == 0;
      for (int i = 0; i < line_buf.size(); i++) begin
         if (src_gap_odds != 0 && $urandom_range(0, 24) == 0) send_char(alie_pkg::CH_NUL, 1'b0);
         send_char(line_buf[i], !nul_last && i == line_buf.size() - 1);
      end
      if (nul_last) send_char(alie_pkg::CH_NUL, 1'b1);
      line_buf.delete();
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   task automatic send_text(input string s);
      add_text(s);
      send_line(1'b0);
   endtask

   function automatic void add_blanks(int most);
      int pick;
      repeat ($urandom_range(0, most)) begin
         pick = $urandom_range(0, 6);
         line_buf.push_back(pick > 4 ? alie_pkg::CH_SPACE : alie_pkg::CH_TAB + 8'(pick));
      end
   endfunction

   function automatic string any_name(mnemonic_group_type grp);
      case (grp)
         GROUP_COMP: return comp_names[$urandom_range(0, 27)];
         GROUP_DEST: return dest_names[$urandom_range(0, 7)];
         default:    return jump_names[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic void add_field(mnemonic_group_type grp);
      int pick;
      pick = $urandom_range(0, 19);
      add_blanks(2);
      if (pick < 16) begin
         add_text(any_name(grp));
      end else if (pick == 17) begin
         add_text("D");
         line_buf.push_back(alie_pkg::CH_SPACE);
         add_text("M");
      end else if (pick == 18) begin
         add_text("ADMDADMDA");
      end else if (pick == 19) begin
         line_buf.push_back(8'($urandom_range(33, 255)));
      end
      add_blanks(2);
   endfunction

   function automatic void add_tail();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
         add_blanks(2);
         add_text("//");
         repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(32, 255)));
      end else if (pick == 4) begin
         line_buf.push_back(alie_pkg::CH_SLASH);
         if ($urandom_range(0, 1)) add_text("x");
      end else if (pick == 5) begin
         add_blanks(3);
      end
   endfunction

   function automatic void build_random_line();
      int pick;
      int digits;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         add_blanks(2);
         if ($urandom_range(0, 9) < 6) begin
            add_field(GROUP_DEST);
            line_buf.push_back(alie_pkg::CH_EQ);
         end
         add_field(GROUP_COMP);
         if ($urandom_range(0, 1)) begin
            line_buf.push_back(alie_pkg::CH_SEMI);
            add_field(GROUP_JUMP);
         end
         if ($urandom_range(0, 19) == 0) begin
            line_buf.push_back($urandom_range(0, 1) ? alie_pkg::CH_EQ : alie_pkg::CH_SEMI);
         end
         add_tail();
      end else if (pick < 70) begin
         add_blanks(1);
         line_buf.push_back(alie_pkg::CH_AT);
         add_blanks(2);
         case ($urandom_range(0, 9))
            0: line_buf.push_back(alie_pkg::CH_PLUS);
            1: line_buf.push_back(alie_pkg::CH_MINUS);
            default: ;
         endcase
         digits = $urandom_range(0, 9);
         case (digits)
            0: ;
            1: add_text("32767");
            2: add_text("32768");
            3: add_text("0");
            4: add_text($sformatf("000%0d", $urandom_range(0, 999)));
            5: add_text($sformatf("%0d", $urandom));
            default: add_text($sformatf("%0d", $urandom_range(0, 40000)));
         endcase
         if ($urandom_range(0, 9) == 0) add_text("x9");
         add_tail();
      end else if (pick < 78) begin
         add_blanks(1);
         line_buf.push_back(alie_pkg::CH_LPAREN);
         add_text($sformatf("L%0d)", $urandom_range(0, 99)));
         add_tail();
      end else if (pick < 85) begin
         add_blanks(3);
         if ($urandom_range(0, 1)) add_tail();
      end else begin
         repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic test_address_forms();
      send_text("@0");
      send_text("@32767");
      send_text("@32768");
      send_text("@ +12");
      send_text("@-0");
      send_text("@-5");
      send_text("@");
      send_text("@-");
      send_text("@65535999");
      send_text("@12abc");
      send_text("@7//9");
      send_text("@ 1 2");
   endtask

   task automatic test_compute_forms();
      send_text("AMD=D|M;JMP");
      send_text("M=M+1");
      send_text("0;JMP");
      send_text("  D  ");
      send_text("D;JGT");
      send_text("A D=1");
      send_text("ADMDADMDA=0");
      send_text("=D");
      send_text("D=");
      send_text("D;");
      send_text("D=A=1");
      send_text("0;JMP;JMP");
      send_text("D=A/");
      add_text("D=");
      line_buf.push_back(8'h80);
      send_line(1'b0);
   endtask

   task automatic test_blank_and_comment_lines();
      send_line(1'b1);
      send_text(" \t ");
      send_text("(LOOP)");
      send_text("// note");
      send_text("D=M // x");
      send_text("@5/");
      add_text("(x");
      send_line(1'b1);
      add_text("D");
      line_buf.push_back(alie_pkg::CH_NUL);
      add_text("=1");
      send_line(1'b1);
      add_text("@1");
      line_buf.push_back(8'hFF);
      send_line(1'b0);
   endtask

   task automatic test_mnemonics();
      for (int i = 0; i < 28; i++) begin
         send_text({dest_names[i % 8], "=", comp_names[i], ";", jump_names[(i + 3) % 8]});
      end
      for (int i = 0; i < 8; i++) send_text({"D;", jump_names[i]});
   endtask

   task automatic test_random_lines(input int item_count, input bit vary_gaps);
      int stop_at;
      stop_at = chars_sent + item_count;
      while (chars_sent < stop_at) begin
         if (vary_gaps && $urandom_range(0, 29) == 0) begin
            src_gap_odds = $urandom_range(0, 2) * 5;
            snk_gap_odds = $urandom_range(0, 2) * 5;
         end
         build_random_line();
         send_line($urandom_range(0, 4) == 0);
      end
   endtask

   // The result side holds off while lines keep coming, so the block has to stall its input.
   task automatic test_back_pressure();
      src_gap_odds = 0;
      snk_gap_odds = 0;
      hold_off_request = 400;
      repeat (20) begin
         build_random_line();
         send_line(1'b0);
      end
   endtask

   task automatic test_flat_out();
      src_gap_odds = 0;
      snk_gap_odds = 0;
      test_random_lines(250, 1'b0);
   endtask

   initial begin
      mismatch_count   = 0;
      chars_sent       = 0;
      hold_off_request = 0;
      src_gap_odds     = 5;
      snk_gap_odds     = 5;
      reset_line();
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.char_code <= alie_pkg::CH_NUL;
      req_chan.line_end  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_address_forms();
      test_compute_forms();
      test_blank_and_comment_lines();
      test_mnemonics();
      test_random_lines(420, 1'b1);
      test_back_pressure();
      src_gap_odds = 5;
      snk_gap_odds = 5;
      test_random_lines(100, 1'b1);
      test_flat_out();
      req_chan.valid <= 1'b0;
      while (encodings_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
